// ===== sv/rgbhsv_pkg.sv =====
// Shared constants for the RGB to HSV converter.
// No dependencies; used by rgb_to_hsv_converter_top.
package rgbhsv_pkg;

	localparam int unsigned LevelW  = 8;
	localparam int unsigned HueW    = 15;
	localparam int unsigned SatW    = 16;

	// hue is counted in 1/64 degree: one 60 degree sector and a full turn
	localparam int unsigned HueSector = 3840;
	localparam int unsigned HueTurn   = 23040;

	// dividend of the hue quotient: 3840 * |diff| < 2^20
	localparam int unsigned HueNumW  = 20;
	// quotient bits: hue magnitude is at most 3840 -> 12 bits
	localparam int unsigned HueQW    = 12;
	// saturation quotient bits, delta < max gives a 16-bit fraction
	localparam int unsigned DivSteps = SatW;

	localparam int unsigned InDataW  = 24;
	localparam int unsigned OutDataW = 40;

	localparam logic [SatW-1:0] SatMax = '1;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

endpackage

// ===== sv/rgb_to_hsv_converter_top.sv =====
// RGB to HSV converter: streaming top level with max/min select, two
// restoring long dividers run side by side, and the hue/saturation fix-up.
// Depends on rgbhsv_pkg.

// One pixel is accepted per clock while the output is not stalled. Each pixel passes
// one compare stage, one stage that sets up the dividends, 16 divider
// stages that each retire one quotient bit, and one output stage. The depth
// is set by the 16-bit saturation divide; the hue divide finishes in the
// first 12 of those stages. A stall on the output side holds the whole
// pipeline, so s_axis_tready follows m_axis_tready while the output is full.
// Hue is in 1/64 degree (0..23039), saturation is delta/max as Q0.16
// saturated at 65535, value is the largest level.
module rgb_to_hsv_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// red_level [7:0], green_level [15:8], blue_level [23:16]
	input  logic [rgbhsv_pkg::InDataW-1:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// hue_angle [14:0], saturation_frac [30:15], value_level [38:31], zero [39]
	output logic [rgbhsv_pkg::OutDataW-1:0] m_axis_tdata
);

	localparam int unsigned LW = rgbhsv_pkg::LevelW;

	typedef struct packed {
		rgbhsv_pkg::sector_t            sector;
		logic [LW-1:0]                  mx;
		logic [LW-1:0]                  delta;
		logic signed [LW:0]             diff;
	} front_t;

	typedef struct packed {
		rgbhsv_pkg::sector_t            sector;
		logic [LW-1:0]                  mx;
		logic [LW-1:0]                  delta;
		logic                           neg;
		logic [LW-1:0]                  hrem;
		logic [rgbhsv_pkg::HueQW-1:0]   hnum;
		logic [rgbhsv_pkg::HueQW-1:0]   hq;
		logic [LW-1:0]                  srem;
		logic [rgbhsv_pkg::SatW-1:0]    sq;
	} div_t;

	logic en;

	// ---------------- stage 1: max, min, sector ----------------
	logic [LW-1:0] r, g, b;
	front_t        front_d;
	front_t        front_s1;
	logic          v_s1;

	assign r = s_axis_tdata[LW-1:0];
	assign g = s_axis_tdata[2*LW-1:LW];
	assign b = s_axis_tdata[3*LW-1:2*LW];

	always_comb begin
		logic [LW-1:0] mn;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		front_d = '0;
		priority if (r >= g && r >= b) begin
			front_d.sector = rgbhsv_pkg::SEC_RED;
			front_d.mx     = r;
			front_d.diff   = $signed({1'b0, g}) - $signed({1'b0, b});
		end else if (g >= b) begin
			front_d.sector = rgbhsv_pkg::SEC_GREEN;
			front_d.mx     = g;
			front_d.diff   = $signed({1'b0, b}) - $signed({1'b0, r});
		end else begin
			front_d.sector = rgbhsv_pkg::SEC_BLUE;
			front_d.mx     = b;
			front_d.diff   = $signed({1'b0, r}) - $signed({1'b0, g});
		end
		front_d.delta = front_d.mx - mn;
	end

	always_ff @(posedge clk) begin
		if (en) front_s1 <= front_d;
	end

	// ---------------- divider setup ----------------
	div_t div_s [0:rgbhsv_pkg::DivSteps];
	logic div_v [0:rgbhsv_pkg::DivSteps];
	div_t div_init;

	always_comb begin
		logic [LW-1:0]                  mag;
		logic [rgbhsv_pkg::HueNumW-1:0] num;
		mag = front_s1.diff[LW] ? LW'(-front_s1.diff) : front_s1.diff[LW-1:0];
		// 3840 * mag = mag * 4096 - mag * 256
		num = ({mag, 12'd0}) - ({4'd0, mag, 8'd0});
		div_init        = '0;
		div_init.sector = front_s1.sector;
		div_init.mx     = front_s1.mx;
		div_init.delta  = front_s1.delta;
		div_init.neg    = front_s1.diff[LW];
		div_init.hrem   = num[rgbhsv_pkg::HueNumW-1:rgbhsv_pkg::HueQW];
		div_init.hnum   = num[rgbhsv_pkg::HueQW-1:0];
		div_init.hq     = '0;
		// delta < max except when fully saturated, handled at the end
		div_init.srem   = front_s1.delta;
		div_init.sq     = '0;
	end

	always_ff @(posedge clk) begin
		if (en) div_s[0] <= div_init;
	end

	// ---------------- divider stages ----------------
	for (genvar i = 0; i < rgbhsv_pkg::DivSteps; i++) begin : g_div
		div_t nxt;

		always_comb begin
			logic [LW:0] ht, st;
			nxt = div_s[i];
			st  = {div_s[i].srem, 1'b0};
			if (st >= {1'b0, div_s[i].mx}) begin
				nxt.srem = LW'(st - {1'b0, div_s[i].mx});
				nxt.sq   = {div_s[i].sq[rgbhsv_pkg::SatW-2:0], 1'b1};
			end else begin
				nxt.srem = st[LW-1:0];
				nxt.sq   = {div_s[i].sq[rgbhsv_pkg::SatW-2:0], 1'b0};
			end
			if (i < rgbhsv_pkg::HueQW) begin
				ht = {div_s[i].hrem, div_s[i].hnum[rgbhsv_pkg::HueQW-1]};
				nxt.hnum = {div_s[i].hnum[rgbhsv_pkg::HueQW-2:0], 1'b0};
				if (ht >= {1'b0, div_s[i].delta}) begin
					nxt.hrem = LW'(ht - {1'b0, div_s[i].delta});
					nxt.hq   = {div_s[i].hq[rgbhsv_pkg::HueQW-2:0], 1'b1};
				end else begin
					nxt.hrem = ht[LW-1:0];
					nxt.hq   = {div_s[i].hq[rgbhsv_pkg::HueQW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) div_s[i+1] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[i+1] <= 1'b0;
			end else if (en) begin
				div_v[i+1] <= div_v[i];
			end
		end
	end

	// ---------------- output fix-up ----------------
	localparam int unsigned Last = rgbhsv_pkg::DivSteps;

	logic [rgbhsv_pkg::HueW-1:0]  hue_d;
	logic [rgbhsv_pkg::SatW-1:0]  sat_d;
	logic [rgbhsv_pkg::HueW-1:0]  hue_q;
	logic [rgbhsv_pkg::SatW-1:0]  sat_q;
	logic [LW-1:0]                val_q;
	logic                         vout_q;

	always_comb begin
		logic [rgbhsv_pkg::HueQW:0] mag;
		logic signed [16:0]         base;
		logic signed [16:0]         h;
		// floor of a negative quotient rounds the magnitude up
		mag = {1'b0, div_s[Last].hq} +
			{{rgbhsv_pkg::HueQW{1'b0}}, (div_s[Last].neg && div_s[Last].hrem != '0)};
		unique case (div_s[Last].sector)
			rgbhsv_pkg::SEC_RED:   base = 17'sd0;
			rgbhsv_pkg::SEC_GREEN: base = 17'(2 * rgbhsv_pkg::HueSector);
			rgbhsv_pkg::SEC_BLUE:  base = 17'(4 * rgbhsv_pkg::HueSector);
			default:               base = 17'sd0;
		endcase
		if (div_s[Last].neg) h = base - $signed({4'd0, mag});
		else                 h = base + $signed({4'd0, mag});
		if (h < 0) h = h + 17'(rgbhsv_pkg::HueTurn);
		if (div_s[Last].delta == '0) hue_d = '0;
		else                         hue_d = h[rgbhsv_pkg::HueW-1:0];

		priority if (div_s[Last].mx == '0)                 sat_d = '0;
		else if (div_s[Last].delta == div_s[Last].mx)      sat_d = rgbhsv_pkg::SatMax;
		else                                               sat_d = div_s[Last].sq;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= hue_d;
			sat_q <= sat_d;
			val_q <= div_s[Last].mx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			div_v[0] <= 1'b0;
			vout_q   <= 1'b0;
		end else if (en) begin
			v_s1     <= s_axis_tvalid;
			div_v[0] <= v_s1;
			vout_q   <= div_v[Last];
		end
	end

	assign en            = !vout_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vout_q;
	assign m_axis_tdata  = {1'b0, val_q, sat_q, hue_q};

`ifndef SYNTHESIS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> hue_q < rgbhsv_pkg::HueTurn)
		else $error("hue out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output request changed while stalled");
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");
	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && val_q == '0 |-> sat_q == '0 && hue_q == '0)
		else $error("black pixel with nonzero hue or saturation");
`endif

endmodule

// ===== tb/rgb_to_hsv_converter_top_tb.sv =====
// Self-checking testbench for rgb_to_hsv_converter_top: directed pixel table, then random pixels
// under several idle/stall mixes; results are checked against typed-in or predicted HSV values.
// Depends on rgbhsv_pkg and rgb_to_hsv_converter_top.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top_tb;

	localparam int SectorSpan = int'(rgbhsv_pkg::HueSector);
	localparam int TurnSpan   = int'(rgbhsv_pkg::HueTurn);
	localparam int SatOne     = 65536;
	localparam int SatTop     = 65535;
	localparam int CycleLimit = 400000;
	localparam int HoldCycles = 300;
	localparam int BurstItems = 50;
	localparam int PhaseItems = 470;
	localparam int DrainWait  = 40;
	localparam int NumRows    = 22;

	typedef struct packed {
		logic [rgbhsv_pkg::HueW-1:0]   hue;
		logic [rgbhsv_pkg::SatW-1:0]   sat;
		logic [rgbhsv_pkg::LevelW-1:0] val;
	} hsv_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		bit          known;
		logic [14:0] hue;
		logic [15:0] sat;
		logic [7:0]  val;
	} pixel_row_t;

	// expected values are typed in only for greys, primaries and ties
	localparam pixel_row_t PixelRows [0:NumRows-1] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, 15'd0,     16'd0,     8'd0},
		'{8'd255, 8'd255, 8'd255, 1'b1, 15'd0,     16'd0,     8'd255},
		'{8'd128, 8'd128, 8'd128, 1'b1, 15'd0,     16'd0,     8'd128},
		'{8'd255, 8'd0,   8'd0,   1'b1, 15'd0,     16'd65535, 8'd255},
		'{8'd0,   8'd255, 8'd0,   1'b1, 15'd7680,  16'd65535, 8'd255},
		'{8'd0,   8'd0,   8'd255, 1'b1, 15'd15360, 16'd65535, 8'd255},
		'{8'd255, 8'd255, 8'd0,   1'b1, 15'd3840,  16'd65535, 8'd255},
		'{8'd0,   8'd255, 8'd255, 1'b1, 15'd11520, 16'd65535, 8'd255},
		'{8'd255, 8'd0,   8'd255, 1'b1, 15'd19200, 16'd65535, 8'd255},
		'{8'd1,   8'd0,   8'd0,   1'b1, 15'd0,     16'd65535, 8'd1},
		'{8'd0,   8'd0,   8'd1,   1'b1, 15'd15360, 16'd65535, 8'd1},
		'{8'd1,   8'd1,   8'd0,   1'b1, 15'd3840,  16'd65535, 8'd1},
		'{8'd255, 8'd0,   8'd1,   1'b0, 15'd0,     16'd0,     8'd0},
		'{8'd255, 8'd1,   8'd0,   1'b0, 15'd0,     16'd0,     8'd0},
		'{8'd254, 8'd255, 8'd0,   1'b0, 15'd0,     16'd0,     8'd0},
		'{8'd255, 8'd254, 8'd254, 1'b0, 15'd0,     16'd0,     8'd0},
		'{8'd1,   8'd2,   8'd3,   1'b0, 15'd0,     16'd0,     8'd0},
		'{8'hAA,  8'h55,  8'hAA,  1'b0, 15'd0,     16'd0,     8'd0},
		'{8'h55,  8'hAA,  8'h55,  1'b0, 15'd0,     16'd0,     8'd0},
		'{8'd200, 8'd100, 8'd150, 1'b0, 15'd0,     16'd0,     8'd0},
		'{8'd3,   8'd255, 8'd254, 1'b0, 15'd0,     16'd0,     8'd0},
		'{8'd100, 8'd200, 8'd200, 1'b0, 15'd0,     16'd0,     8'd0}
	};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [rgbhsv_pkg::InDataW-1:0]  s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [rgbhsv_pkg::OutDataW-1:0] m_axis_tdata;

	hsv_t hsv_pending[$];
	hsv_t next_hsv;
	int   mismatch_count = 0;
	int   cycle_count = 0;
	int   send_pct = 0;
	int   stall_pct = 0;
	int   hold_left = 0;
	bit   hold_req = 1'b0;

	rgb_to_hsv_converter_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	function automatic int floor_quot(input int num, input int den);
		if (num >= 0)
			return num / den;
		return -((-num + den - 1) / den);
	endfunction

	function automatic hsv_t predict_hsv(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int                  ri, gi, bi, top, low, delta, hue, sat;
		rgbhsv_pkg::sector_t sec;
		hsv_t                res;
		ri = r;
		gi = g;
		bi = b;
		// strict compares give red, then green, the win on a tie
		top = ri;
		sec = rgbhsv_pkg::SEC_RED;
		if (gi > top) begin
			top = gi;
			sec = rgbhsv_pkg::SEC_GREEN;
		end
		if (bi > top) begin
			top = bi;
			sec = rgbhsv_pkg::SEC_BLUE;
		end
		low = ri;
		if (gi < low) low = gi;
		if (bi < low) low = bi;
		delta = top - low;
		hue = 0;
		if (delta != 0) begin
			unique case (sec)
				rgbhsv_pkg::SEC_RED:
					hue = floor_quot(SectorSpan * (gi - bi), delta);
				rgbhsv_pkg::SEC_GREEN:
					hue = floor_quot(SectorSpan * (bi - ri), delta) + 2 * SectorSpan;
				default:
					hue = floor_quot(SectorSpan * (ri - gi), delta) + 4 * SectorSpan;
			endcase
		end
		if (hue < 0)
			hue += TurnSpan;
		if (top == 0) begin
			sat = 0;
		end else begin
			sat = (delta * SatOne) / top;
			if (sat > SatTop)
				sat = SatTop;
		end
		res.hue = hue[rgbhsv_pkg::HueW-1:0];
		res.sat = sat[rgbhsv_pkg::SatW-1:0];
		res.val = top[rgbhsv_pkg::LevelW-1:0];
		return res;
	endfunction

	// half the pixels are corner-shaped: greys, tied maxima, dark and full channels
	function automatic logic [rgbhsv_pkg::InDataW-1:0] random_pixel();
		logic [7:0] lv [3];
		int         kind, idx, pair, rest;
		for (int k = 0; k < 3; k++)
			lv[k] = 8'($urandom_range(255));
		kind = $urandom_range(9);
		idx = $urandom_range(2);
		unique case (kind)
			0: begin
				lv[1] = lv[0];
				lv[2] = lv[0];
			end
			1: begin
				pair = (idx + 1) % 3;
				rest = 3 - idx - pair;
				lv[pair] = lv[idx];
				lv[rest] = 8'($urandom_range(lv[idx]));
			end
			2: lv[idx] = 8'd0;
			3: lv[idx] = 8'hFF;
			4: begin
				for (int k = 0; k < 3; k++)
					lv[k] = 8'($urandom_range(3));
			end
			default: ;
		endcase
		return {lv[2], lv[1], lv[0]};
	endfunction

	// drive one pixel request at the falling edge and hold it until taken
	task automatic send_pixel(input logic [rgbhsv_pkg::InDataW-1:0] px, input hsv_t want);
		if ($urandom_range(99) < send_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_pct);
		end
		next_hsv = want;
		s_axis_tdata <= px;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HoldCycles;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		hsv_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (hsv_pending.size() == 0) begin
					$error("result 0x%h with no request outstanding", m_axis_tdata);
					mismatch_count++;
				end else begin
					want = hsv_pending.pop_front();
					check_field("hue_angle", 32'(want.hue), 32'(m_axis_tdata[14:0]));
					check_field("saturation_frac", 32'(want.sat), 32'(m_axis_tdata[30:15]));
					check_field("value_level", 32'(want.val), 32'(m_axis_tdata[38:31]));
					check_field("pad", 32'd0, 32'(m_axis_tdata[39]));
				end
			end
			// a result taken this edge is always older than a request taken now
			if (s_axis_tvalid && s_axis_tready)
				hsv_pending = {hsv_pending, next_hsv};
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("rgb_to_hsv_converter_top regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int   send_mix [4];
		int   stall_mix [4];
		hsv_t want;
		send_mix = '{0, 58, 0, 13};
		stall_mix = '{0, 0, 58, 13};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (PixelRows[k]) begin
			if (PixelRows[k].known)
				want = '{PixelRows[k].hue, PixelRows[k].sat, PixelRows[k].val};
			else
				want = predict_hsv(PixelRows[k].red, PixelRows[k].green, PixelRows[k].blue);
			send_pixel({PixelRows[k].blue, PixelRows[k].green, PixelRows[k].red}, want);
		end

		// long output hold-off with back-to-back requests: pipeline fills, input stalls
		hold_req = 1'b1;
		for (int k = 0; k < BurstItems; k++) begin
			logic [rgbhsv_pkg::InDataW-1:0] px;
			px = random_pixel();
			send_pixel(px, predict_hsv(px[7:0], px[15:8], px[23:16]));
		end
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (hsv_pending.size() != 0);

		for (int ph = 0; ph < 4; ph++) begin
			send_pct = send_mix[ph];
			stall_pct = stall_mix[ph];
			for (int k = 0; k < PhaseItems; k++) begin
				logic [rgbhsv_pkg::InDataW-1:0] px;
				px = random_pixel();
				send_pixel(px, predict_hsv(px[7:0], px[15:8], px[23:16]));
			end
		end
		s_axis_tvalid <= 1'b0;

		while (hsv_pending.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
		if (mismatch_count == 0)
			$display("rgb_to_hsv_converter_top regression: pass");
		else
			$display("rgb_to_hsv_converter_top regression: fail");
		$finish;
	end

endmodule

// ===== rgb_to_hsv_converter_top.f =====
sv/rgbhsv_pkg.sv
sv/rgb_to_hsv_converter_top.sv
tb/rgb_to_hsv_converter_top_tb.sv
